// ===== rtl/core/triangle_sample_diffuse_shader_top_defines.svh =====
// Assertion macros used by the shader FIFO.
`ifndef TRIANGLE_SAMPLE_DIFFUSE_SHADER_TOP_DEFINES_SVH
`define TRIANGLE_SAMPLE_DIFFUSE_SHADER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define TSDS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");
`define TSDS_ASSERT_NEXT(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define TSDS_ASSERT(lbl, clk, rstn, prop)
`define TSDS_ASSERT_NEXT(lbl, clk, rstn, pre, post)
`endif
`endif

// ===== rtl/core/tsds_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package tsds_pkg;

  localparam int unsigned ONE_Q16    = 65536;
  localparam int unsigned RED_MAX    = 32768;
  localparam int unsigned LW         = 50;
  localparam int unsigned NW         = 34;
  localparam int unsigned RW         = 16;
  localparam int unsigned DVW        = 50;
  localparam int unsigned RED_STEPS  = 6;
  localparam int unsigned RED_LAT    = RED_STEPS + 2;
  localparam int unsigned SQ_STAGES  = 32;
  localparam int unsigned DIV_STAGES = 17;
  localparam int unsigned LAT        = 7 + RED_LAT + SQ_STAGES + DIV_STAGES;
  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned CFG_IDX_W  = 3;

  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_POS_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_POS_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_POS_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_RED   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_GREEN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_BLUE  = 3'd5;

  typedef struct packed {
    logic             is_load;
    logic [1:0]       slot;
    logic [2:0][31:0] pos;
    logic [2:0][15:0] nrm;
    logic [2:0][16:0] w;
  } item_t;

  typedef struct packed {
    logic [2:0][31:0] pos;
    logic [2:0][16:0] col;
  } light_t;

  typedef struct packed {
    logic        valid;
    logic [16:0] w0;
    logic [16:0] w1;
  } side_t;

endpackage
`default_nettype wire

// ===== rtl/core/triangle_sample_diffuse_shader_top.sv =====
// Diffuse shading of random points on one triangle.
// The input channel (in_valid_i/in_ready_o) takes two kinds of transfer: a load
// writes one corner's position and normal, and a sample carries s and t and
// yields one result on the output channel (out_valid_o/out_ready_i) holding the
// barycentric weights a, b and the shaded colour. Loads yield no result.
// The configuration channel (cfg_valid_i/cfg_ready_o) is always ready and sets
// the light position and colour; write it only while the block is idle.
// A sample accepted at the input passes through the queue and the shading
// pipeline, which holds the 32-step square root and 17-step divider pipelines.
// One item is accepted per cycle, sustained, while the output is not stalled.
// A two-entry queue separates input acceptance from the shading pipeline.
// When the receiver stalls, the whole pipeline holds, the queue fills, and
// in_ready_o drops after at most two more transfers.
// Reset clears the queue and all valid flags and sets the light to the origin
// with white colour. The corner store is undefined until loaded; it needs no
// clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module triangle_sample_diffuse_shader_top import tsds_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 func_i,
  input  logic [1:0]           vertex_slot_i,
  input  logic signed [31:0]   pos_x_i,
  input  logic signed [31:0]   pos_y_i,
  input  logic signed [31:0]   pos_z_i,
  input  logic signed [15:0]   nrm_x_i,
  input  logic signed [15:0]   nrm_y_i,
  input  logic signed [15:0]   nrm_z_i,
  input  logic [15:0]          samp_s_i,
  input  logic [15:0]          samp_t_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [16:0]          bary_a_o,
  output logic [16:0]          bary_b_o,
  output logic [16:0]          shade_red_o,
  output logic [16:0]          shade_green_o,
  output logic [16:0]          shade_blue_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]          cfg_data_i
);

  light_t light_q;
  item_t  in_item;
  item_t  head;
  logic   full;
  logic   push;
  logic   pop;
  logic   head_valid;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      light_q.pos <= '0;
      for (int ch = 0; ch < 3; ch++) begin
        light_q.col[ch] <= 17'(ONE_Q16);
      end
    end else if (cfg_valid_i) begin
      case (cfg_idx_i)
        CFG_LIGHT_POS_X: light_q.pos[0] <= cfg_data_i;
        CFG_LIGHT_POS_Y: light_q.pos[1] <= cfg_data_i;
        CFG_LIGHT_POS_Z: light_q.pos[2] <= cfg_data_i;
        CFG_LIGHT_RED:   light_q.col[0] <= cfg_data_i[16:0];
        CFG_LIGHT_GREEN: light_q.col[1] <= cfg_data_i[16:0];
        CFG_LIGHT_BLUE:  light_q.col[2] <= cfg_data_i[16:0];
        default: begin
        end
      endcase
    end
  end

  tsds_front u_front (
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .full_i        (full),
    .push_o        (push),
    .func_i        (func_i),
    .vertex_slot_i (vertex_slot_i),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .pos_z_i       (pos_z_i),
    .nrm_x_i       (nrm_x_i),
    .nrm_y_i       (nrm_y_i),
    .nrm_z_i       (nrm_z_i),
    .samp_s_i      (samp_s_i),
    .samp_t_i      (samp_t_i),
    .item_o        (in_item)
  );

  tsds_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (in_item),
    .pop_i   (pop),
    .item_o  (head),
    .valid_o (head_valid),
    .full_o  (full)
  );

  tsds_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .head_valid_i  (head_valid),
    .pop_o         (pop),
    .light_i       (light_q),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .bary_a_o      (bary_a_o),
    .bary_b_o      (bary_b_o),
    .shade_red_o   (shade_red_o),
    .shade_green_o (shade_green_o),
    .shade_blue_o  (shade_blue_o)
  );

endmodule
`default_nettype wire

// ===== rtl/core/tsds_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tsds_front import tsds_pkg::*; (
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               full_i,
  output logic               push_o,
  input  logic               func_i,
  input  logic [1:0]         vertex_slot_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic signed [15:0] nrm_x_i,
  input  logic signed [15:0] nrm_y_i,
  input  logic signed [15:0] nrm_z_i,
  input  logic [15:0]        samp_s_i,
  input  logic [15:0]        samp_t_i,
  output item_t              item_o
);

  logic [16:0] sum;
  logic        fold;
  logic [16:0] s_f;
  logic [16:0] t_f;

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  assign sum  = {1'b0, samp_s_i} + {1'b0, samp_t_i};
  assign fold = sum > 17'(ONE_Q16);
  assign s_f  = fold ? 17'(ONE_Q16) - {1'b0, samp_s_i} : {1'b0, samp_s_i};
  assign t_f  = fold ? 17'(ONE_Q16) - {1'b0, samp_t_i} : {1'b0, samp_t_i};

  always_comb begin
    item_o.is_load = (func_i == FUNC_LOAD);
    item_o.slot    = vertex_slot_i;
    item_o.pos[0]  = pos_x_i;
    item_o.pos[1]  = pos_y_i;
    item_o.pos[2]  = pos_z_i;
    item_o.nrm[0]  = nrm_x_i;
    item_o.nrm[1]  = nrm_y_i;
    item_o.nrm[2]  = nrm_z_i;
    item_o.w[0]    = 17'(ONE_Q16) - s_f - t_f;
    item_o.w[1]    = s_f;
    item_o.w[2]    = t_f;
  end

endmodule
`default_nettype wire

// ===== rtl/core/tsds_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "triangle_sample_diffuse_shader_top_defines.svh"
module tsds_fifo import tsds_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  input  logic  pop_i,
  output item_t item_o,
  output logic  valid_o,
  output logic  full_o
);

  localparam int unsigned PtrW = $clog2(FIFO_DEPTH);
  localparam int unsigned CntW = $clog2(FIFO_DEPTH + 1);

  item_t            mem_q [FIFO_DEPTH];
  logic [PtrW-1:0]  wr_q;
  logic [PtrW-1:0]  rd_q;
  logic [CntW-1:0]  cnt_q;

  assign item_o  = mem_q[rd_q];
  assign valid_o = cnt_q != '0;
  assign full_o  = cnt_q == CntW'(FIFO_DEPTH);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(FIFO_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(FIFO_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push_i && pop_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  `TSDS_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= CntW'(FIFO_DEPTH))
  `TSDS_ASSERT(a_pop_nonempty, clk_i, rst_ni, !pop_i || cnt_q != '0)
  `TSDS_ASSERT(a_push_not_full, clk_i, rst_ni, !(push_i && full_o))
  `TSDS_ASSERT_NEXT(a_push_grows, clk_i, rst_ni, push_i && !pop_i, cnt_q == $past(cnt_q) + 1'b1)

endmodule
`default_nettype wire

// ===== rtl/core/tsds_reduce.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tsds_reduce import tsds_pkg::*; (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [2:0][LW-1:0]  vec_i,
  output logic [2:0][RW-1:0]  red_o,
  output logic                nz_o
);

  logic [LW-1:0] mag_q [RED_STEPS+1][3];
  logic          sgn_q [RED_STEPS+1][3];
  logic [LW-1:0] mx_q  [RED_STEPS+1];
  logic [LW-1:0] mag_in [3];
  logic [LW-1:0] mx_ab;
  logic [LW-1:0] mx_in;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      mag_in[a] = vec_i[a][LW-1] ? LW'(-$signed(vec_i[a])) : vec_i[a];
    end
    mx_ab = (mag_in[0] > mag_in[1]) ? mag_in[0] : mag_in[1];
    mx_in = (mx_ab > mag_in[2]) ? mx_ab : mag_in[2];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mx_q[0] <= mx_in;
      for (int a = 0; a < 3; a++) begin
        mag_q[0][a] <= mag_in[a];
        sgn_q[0][a] <= vec_i[a][LW-1];
      end
    end
  end

  for (genvar j = 1; j <= RED_STEPS; j++) begin : g_step
    localparam int unsigned Step = 1 << (RED_STEPS - j);
    logic take;
    assign take = (mx_q[j-1] >> Step) >= LW'(RED_MAX);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        mx_q[j] <= take ? mx_q[j-1] >> Step : mx_q[j-1];
        for (int a = 0; a < 3; a++) begin
          mag_q[j][a] <= take ? mag_q[j-1][a] >> Step : mag_q[j-1][a];
          sgn_q[j][a] <= sgn_q[j-1][a];
        end
      end
    end
  end

  logic          last;
  logic [LW-1:0] m_fin [3];

  assign last = mx_q[RED_STEPS] >= LW'(RED_MAX);

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      m_fin[a] = last ? mag_q[RED_STEPS][a] >> 1 : mag_q[RED_STEPS][a];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nz_o <= mx_q[RED_STEPS] != '0;
      for (int a = 0; a < 3; a++) begin
        red_o[a] <= sgn_q[RED_STEPS][a] ? RW'(-m_fin[a][RW-1:0]) : m_fin[a][RW-1:0];
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/tsds_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tsds_back import tsds_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  item_t       head_i,
  input  logic        head_valid_i,
  output logic        pop_o,
  input  light_t      light_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [16:0] bary_a_o,
  output logic [16:0] bary_b_o,
  output logic [16:0] shade_red_o,
  output logic [16:0] shade_green_o,
  output logic [16:0] shade_blue_o
);

  function automatic logic [16:0] shade_fn(input logic [16:0] col, input logic [16:0] q);
    logic [34:0] prod;
    logic [18:0] v;
    prod = 35'(col) * 35'(q) + 35'(RED_MAX);
    v    = prod[34:16];
    return (v > 19'(ONE_Q16)) ? 17'(ONE_Q16) : v[16:0];
  endfunction

  logic               adv;
  side_t              sb_q [LAT];
  logic signed [31:0] cpos_q [9];
  logic signed [15:0] cnrm_q [9];
  logic [16:0]        w_q [3];
  logic signed [LW-1:0] pp_q [9];
  logic signed [NW-1:0] np_q [9];
  logic signed [LW-1:0] psum_q [3];
  logic signed [NW-1:0] nsum_q [3];
  logic [2:0][LW-1:0] lvec_q;
  logic [2:0][LW-1:0] nvec_q;
  logic [2:0][RW-1:0] rn;
  logic [2:0][RW-1:0] rl;
  logic               nz_n;
  logic               nz_l;
  logic signed [31:0] dp_q [3];
  logic [31:0]        nsq_q [3];
  logic [31:0]        lsq_q [3];
  logic               nz1_q;
  logic signed [33:0] dot_q;
  logic [31:0]        nn_q;
  logic [31:0]        ll_q;
  logic               nz2_q;
  logic [63:0]        sq_x_q    [SQ_STAGES+1];
  logic [34:0]        sq_rem_q  [SQ_STAGES+1];
  logic [31:0]        sq_root_q [SQ_STAGES+1];
  logic [31:0]        sq_d_q    [SQ_STAGES+1];
  logic               sq_pos_q  [SQ_STAGES+1];
  logic [DVW-1:0]     dv_rem_q  [1:DIV_STAGES];
  logic [31:0]        dv_r_q    [1:DIV_STAGES];
  logic [16:0]        dv_quo_q  [1:DIV_STAGES];
  logic               dv_pos_q  [1:DIV_STAGES];
  logic [16:0]        q_raw;
  logic [16:0]        q_cap;
  logic               out_valid_q;
  logic [16:0]        bary_a_q;
  logic [16:0]        bary_b_q;
  logic [16:0]        shade_q [3];

  assign adv   = !out_valid_q || out_ready_i;
  assign pop_o = adv && head_valid_i;

  always_ff @(posedge clk_i) begin
    if (pop_o && head_i.is_load) begin
      for (int c = 0; c < 3; c++) begin
        if (head_i.slot == 2'(c)) begin
          for (int a = 0; a < 3; a++) begin
            cpos_q[c*3+a] <= head_i.pos[a];
            cnrm_q[c*3+a] <= head_i.nrm[a];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < LAT; k++) begin
        sb_q[k] <= '0;
      end
    end else if (adv) begin
      sb_q[0] <= '{valid: pop_o && !head_i.is_load, w0: head_i.w[0], w1: head_i.w[1]};
      for (int k = 1; k < LAT; k++) begin
        sb_q[k] <= sb_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int c = 0; c < 3; c++) begin
        w_q[c] <= head_i.w[c];
        for (int a = 0; a < 3; a++) begin
          pp_q[c*3+a] <= $signed({1'b0, w_q[c]}) * cpos_q[c*3+a];
          np_q[c*3+a] <= $signed({1'b0, w_q[c]}) * cnrm_q[c*3+a];
        end
      end
      for (int a = 0; a < 3; a++) begin
        psum_q[a] <= pp_q[a] + pp_q[3+a] + pp_q[6+a];
        nsum_q[a] <= np_q[a] + np_q[3+a] + np_q[6+a];
        lvec_q[a] <= (LW'($signed(light_i.pos[a])) <<< 16) - psum_q[a];
        nvec_q[a] <= LW'(nsum_q[a]);
      end
    end
  end

  tsds_reduce u_red_n (
    .clk_i (clk_i),
    .en_i  (adv),
    .vec_i (nvec_q),
    .red_o (rn),
    .nz_o  (nz_n)
  );

  tsds_reduce u_red_l (
    .clk_i (clk_i),
    .en_i  (adv),
    .vec_i (lvec_q),
    .red_o (rl),
    .nz_o  (nz_l)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int a = 0; a < 3; a++) begin
        dp_q[a]  <= $signed(rn[a]) * $signed(rl[a]);
        nsq_q[a] <= $signed(rn[a]) * $signed(rn[a]);
        lsq_q[a] <= $signed(rl[a]) * $signed(rl[a]);
      end
      nz1_q <= nz_n && nz_l;
      dot_q <= 34'(dp_q[0]) + 34'(dp_q[1]) + 34'(dp_q[2]);
      nn_q  <= nsq_q[0] + nsq_q[1] + nsq_q[2];
      ll_q  <= lsq_q[0] + lsq_q[1] + lsq_q[2];
      nz2_q <= nz1_q;
      sq_x_q[0]    <= nn_q * ll_q;
      sq_rem_q[0]  <= '0;
      sq_root_q[0] <= '0;
      sq_d_q[0]    <= dot_q[31:0];
      sq_pos_q[0]  <= nz2_q && (dot_q > 34'sd0);
    end
  end

  for (genvar k = 1; k <= SQ_STAGES; k++) begin : g_sq
    localparam int unsigned Pair = SQ_STAGES - k;
    logic [34:0] cand;
    logic [34:0] trial;
    logic        ge;
    assign cand  = {sq_rem_q[k-1][32:0], sq_x_q[k-1][2*Pair+1 -: 2]};
    assign trial = {1'b0, sq_root_q[k-1], 2'b01};
    assign ge    = cand >= trial;
    always_ff @(posedge clk_i) begin
      if (adv) begin
        sq_x_q[k]    <= sq_x_q[k-1];
        sq_rem_q[k]  <= ge ? cand - trial : cand;
        sq_root_q[k] <= {sq_root_q[k-1][30:0], ge};
        sq_d_q[k]    <= sq_d_q[k-1];
        sq_pos_q[k]  <= sq_pos_q[k-1];
      end
    end
  end

  for (genvar j = 1; j <= DIV_STAGES; j++) begin : g_div
    localparam int unsigned Bit = DIV_STAGES - j;
    logic [DVW-1:0] rem_in;
    logic [31:0]    r_in;
    logic [16:0]    q_in;
    logic           pos_in;
    logic [DVW-1:0] sub;
    logic           ge;
    if (j == 1) begin : g_first
      assign rem_in = DVW'({sq_d_q[SQ_STAGES], 16'h0000});
      assign r_in   = sq_root_q[SQ_STAGES];
      assign q_in   = '0;
      assign pos_in = sq_pos_q[SQ_STAGES];
    end else begin : g_rest
      assign rem_in = dv_rem_q[j-1];
      assign r_in   = dv_r_q[j-1];
      assign q_in   = dv_quo_q[j-1];
      assign pos_in = dv_pos_q[j-1];
    end
    assign sub = DVW'(r_in) << Bit;
    assign ge  = rem_in >= sub;
    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv_rem_q[j] <= ge ? rem_in - sub : rem_in;
        dv_r_q[j]   <= r_in;
        dv_quo_q[j] <= {q_in[15:0], ge};
        dv_pos_q[j] <= pos_in && (r_in != '0);
      end
    end
  end

  assign q_raw = dv_pos_q[DIV_STAGES] ? dv_quo_q[DIV_STAGES] : '0;
  assign q_cap = (q_raw > 17'(ONE_Q16)) ? 17'(ONE_Q16) : q_raw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= sb_q[LAT-1].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      bary_a_q <= sb_q[LAT-1].w0;
      bary_b_q <= sb_q[LAT-1].w1;
      for (int ch = 0; ch < 3; ch++) begin
        shade_q[ch] <= shade_fn(light_i.col[ch], q_cap);
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign bary_a_o      = bary_a_q;
  assign bary_b_o      = bary_b_q;
  assign shade_red_o   = shade_q[0];
  assign shade_green_o = shade_q[1];
  assign shade_blue_o  = shade_q[2];

endmodule
`default_nettype wire
